// ----- hdl/rdp_pkg.sv -----
// ----------------------------------------------------------------------------
// rdp_pkg
// Shared constants and types for the rotary dial pulse decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rdp_pkg;

    localparam int unsigned TIMER_W = 6;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned LEN_W   = 6;

    localparam logic [LEN_W-1:0]   MAX_DIGITS     = 6'd32;
    localparam logic [TIMER_W-1:0] DEBOUNCE_RESET = 6'd10;
    localparam logic [TIMER_W-1:0] TIMER_MAX      = 6'd63;
    localparam logic [COUNT_W-1:0] PULSE_MAX      = 4'd15;
    localparam logic [COUNT_W-1:0] PULSES_ZERO    = 4'd10;

    typedef struct packed {
        logic level;
        logic changed;
    } deb_status_t;

endpackage

`default_nettype wire

// ----- hdl/rdp_debounce.sv -----
// ----------------------------------------------------------------------------
// rdp_debounce
// Per-contact debouncer: restart timer on raw change, accept level once the
// timer reaches the debounce count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdp_debounce (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic                        raw,
    input  wire logic [rdp_pkg::TIMER_W-1:0] debounce_ms,
    output rdp_pkg::deb_status_t             status
);
    import rdp_pkg::*;

    logic               prev_reg;
    logic               stable_reg;
    logic [TIMER_W-1:0] timer_reg;
    logic [TIMER_W-1:0] timer_next;
    logic               changed;

    always_comb
    begin
        if (raw != prev_reg)
        begin
            timer_next = '0;
        end
        else if (timer_reg < TIMER_MAX)
        begin
            timer_next = timer_reg + 1'b1;
        end
        else
        begin
            timer_next = timer_reg;
        end
        changed        = (timer_next >= debounce_ms) && (raw != stable_reg);
        status.changed = changed;
        status.level   = changed ? raw : stable_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= 1'b1;
            stable_reg <= 1'b1;
            timer_reg  <= '0;
        end
        else if (step)
        begin
            prev_reg   <= raw;
            stable_reg <= status.level;
            timer_reg  <= timer_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rotary_dial_pulse_decoder.sv -----
// ----------------------------------------------------------------------------
// rotary_dial_pulse_decoder
// Debounces the off-normal and pulse contacts and reports dialed digits.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side s_*: one beat per millisecond tick carrying the raw contact
//   levels and the clear request. Master side m_*: exactly one result beat
//   per input beat, in order.
//   The result is in m_tdata the cycle after acceptance. Throughput: one
//   beat per cycle unless stalled. All state is updated by short logic in
//   the cycle of acceptance; the result register is the only stage.
//   s_tready is high whenever the result register is empty or being taken,
//   so a stalled receiver holds the result and stops intake after one beat.
//   Reset: contacts idle high, timers and pulse count zero, number empty,
//   debounce count 10, no result pending.
//   cfg_we/cfg_data write the debounce count in ticks; write while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rotary_dial_pulse_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [5:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] in_dial_level, [1] pulse_level, [2] clear_number, [7:3] zero
    input  wire logic [7:0]  s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] digit_valid, [4:1] digit, [10:5] digit_position, [11] appended,
    // [12] dialing, [15:13] zero
    output logic [15:0]      m_tdata
);
    import rdp_pkg::*;

    logic [TIMER_W-1:0] debounce_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [LEN_W-1:0]   length_reg;
    logic [LEN_W-1:0]   length_next;
    logic               out_valid_reg;
    logic [15:0]        out_data_reg;
    logic [15:0]        out_data_next;

    logic               accept;
    deb_status_t        dial_st;
    deb_status_t        pulse_st;

    logic               digit_valid;
    logic [COUNT_W-1:0] digit;
    logic [LEN_W-1:0]   digit_position;
    logic               appended;
    logic [LEN_W-1:0]   base_len;
    logic [COUNT_W-1:0] count_mid;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    rdp_debounce u_dial_deb (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .raw         (s_tdata[0]),
        .debounce_ms (debounce_reg),
        .status      (dial_st)
    );

    rdp_debounce u_pulse_deb (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .raw         (s_tdata[1]),
        .debounce_ms (debounce_reg),
        .status      (pulse_st)
    );

    always_comb
    begin
        base_len       = s_tdata[2] ? '0 : length_reg;
        length_next    = base_len;
        count_mid      = count_reg;
        digit_valid    = 1'b0;
        digit          = '0;
        digit_position = '0;
        appended       = 1'b0;

        if (dial_st.changed)
        begin
            if (!dial_st.level)
            begin
                count_mid = '0;
            end
            else if (count_reg != '0)
            begin
                if (count_reg == PULSES_ZERO)
                begin
                    count_mid = '0;
                end
                digit_valid    = 1'b1;
                digit          = count_mid;
                digit_position = base_len;
                if (base_len < MAX_DIGITS)
                begin
                    appended    = 1'b1;
                    length_next = base_len + 1'b1;
                end
            end
        end

        count_next = count_mid;
        if (pulse_st.changed && !pulse_st.level && (count_mid < PULSE_MAX))
        begin
            count_next = count_mid + 1'b1;
        end

        out_data_next = {3'b000, !dial_st.level, appended, digit_position,
                         digit, digit_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RESET;
            count_reg     <= '0;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                debounce_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                length_reg    <= length_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= MAX_DIGITS)
        else $error("number length beyond capacity");

    a_append_needs_digit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[11] |-> m_tdata[0])
        else $error("append without digit");

    a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[10:1] == '0))
        else $error("digit fields set without digit");

    a_length_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !s_tdata[2] |=> (length_reg == $past(length_reg))
            || (length_reg == $past(length_reg) + 1'b1))
        else $error("number length jumped");
`endif

endmodule

`default_nettype wire
